### design/tcp_option_parser_unit_defines.svh
// Assertion macros shared by the option parser RTL.
`ifndef TCP_OPTION_PARSER_UNIT_DEFINES_SVH
`define TCP_OPTION_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define TOP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcp option parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TOP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcp option parser: next-cycle check failed");

`else

`define TOP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TOP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/tcp_opt_pkg.sv
// Types and constants shared by the TCP option parser modules.
package tcp_opt_pkg;

  localparam int SACK_SLOTS = 3;

  localparam logic [7:0] KIND_EOL  = 8'd0;
  localparam logic [7:0] KIND_NOP  = 8'd1;
  localparam logic [7:0] KIND_SACK = 8'd5;
  localparam logic [7:0] KIND_TS   = 8'd8;
  localparam logic [7:0] TS_LEN    = 8'd10;
  localparam logic [7:0] MIN_LEN   = 8'd2;

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef struct packed {
    logic                         has_ts;
    logic [31:0]                  ts_value;
    logic [31:0]                  ts_echo;
    logic [1:0]                   sack_count;
    logic [SACK_SLOTS-1:0][31:0]  sack_left;
    logic [SACK_SLOTS-1:0][31:0]  sack_right;
  } result_t;

endpackage

### design/tcp_opt_walk.sv
// Option record walker: per-byte parse state and captured timestamp/SACK fields.
module tcp_opt_walk
  import tcp_opt_pkg::*;
#(
  parameter int MAX_BLOCKS     = 3,
  parameter int MAX_AREA_BYTES = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] opt_byte,
  input  logic [5:0] area_len,
  input  logic       last,
  output result_t    result
);

  logic [5:0]  pos;
  phase_t      phase;
  logic [7:0]  cur_kind;
  logic [7:0]  remaining;
  logic [5:0]  body_off;
  logic [31:0] word;
  logic        ts_seen;
  logic [31:0] ts_val;
  logic [31:0] ts_echo;
  logic [31:0] ts_hold;
  logic [1:0]  sack_cnt;
  logic [31:0] sack_left  [MAX_BLOCKS];
  logic [31:0] sack_right [MAX_BLOCKS];

  logic [5:0]  pos_next;
  phase_t      phase_next;
  logic [7:0]  cur_kind_next;
  logic [7:0]  remaining_next;
  logic [5:0]  body_off_next;
  logic [31:0] word_next;
  logic        ts_seen_next;
  logic [31:0] ts_val_next;
  logic [31:0] ts_echo_next;
  logic [31:0] ts_hold_next;
  logic [1:0]  sack_cnt_next;
  logic [31:0] sack_left_next  [MAX_BLOCKS];
  logic [31:0] sack_right_next [MAX_BLOCKS];

  logic [5:0]  len_eff;
  logic        in_area;
  logic [31:0] word_new;
  logic [5:0]  off_new;
  logic        wr_left;
  logic        wr_right;

  assign len_eff  = (area_len > 6'(MAX_AREA_BYTES)) ? 6'(MAX_AREA_BYTES) : area_len;
  assign in_area  = (phase != PH_STOP) && (pos < len_eff);
  assign word_new = {word[23:0], opt_byte};
  assign off_new  = body_off + 6'd1;

  always_comb begin
    phase_next     = phase;
    cur_kind_next  = cur_kind;
    remaining_next = remaining;
    body_off_next  = body_off;
    word_next      = word;
    ts_seen_next   = ts_seen;
    ts_val_next    = ts_val;
    ts_echo_next   = ts_echo;
    ts_hold_next   = ts_hold;
    sack_cnt_next  = sack_cnt;
    wr_left        = 1'b0;
    wr_right       = 1'b0;
    pos_next       = (pos == 6'd63) ? pos : pos + 6'd1;

    if (in_area) begin
      unique case (phase)
        PH_KIND: begin
          if (opt_byte == KIND_EOL) begin
            phase_next = PH_STOP;
          end else if (opt_byte == KIND_NOP) begin
            phase_next = PH_KIND;
          end else if (({1'b0, pos} + 7'd1) >= {1'b0, len_eff}) begin
            // A kind with no room left for its length byte ends the walk.
            phase_next = PH_STOP;
          end else begin
            cur_kind_next = opt_byte;
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          if ((opt_byte < MIN_LEN) ||
              ({3'b000, pos - 6'd1} + {1'b0, opt_byte} > {3'b000, len_eff})) begin
            phase_next = PH_STOP;
          end else begin
            if (cur_kind == KIND_TS) begin
              cur_kind_next = (opt_byte == TS_LEN) ? cur_kind : KIND_EOL;
            end else if (cur_kind != KIND_SACK) begin
              cur_kind_next = KIND_EOL;
            end
            remaining_next = opt_byte - MIN_LEN;
            body_off_next  = '0;
            phase_next     = (opt_byte == MIN_LEN) ? PH_KIND : PH_BODY;
          end
        end
        PH_BODY: begin
          word_next     = word_new;
          body_off_next = off_new;
          if (cur_kind == KIND_TS) begin
            if (off_new == 6'd4) begin
              ts_hold_next = word_new;
            end else if (off_new == 6'd8) begin
              ts_val_next  = ts_hold;
              ts_echo_next = word_new;
              ts_seen_next = 1'b1;
            end
          end else if ((cur_kind == KIND_SACK) && (sack_cnt < 2'(MAX_BLOCKS))) begin
            // Each SACK block is eight body bytes: left edge, then right edge.
            if (off_new[2:0] == 3'd4) begin
              wr_left = 1'b1;
            end else if (off_new[2:0] == 3'd0) begin
              wr_right      = 1'b1;
              sack_cnt_next = sack_cnt + 2'd1;
            end
          end
          remaining_next = (remaining != 8'd0) ? remaining - 8'd1 : remaining;
          if (remaining_next == 8'd0) begin
            phase_next = PH_KIND;
          end
        end
        PH_STOP: begin
          phase_next = PH_STOP;
        end
        default: begin
          phase_next = PH_STOP;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      sack_left_next[i]  = (wr_left && (sack_cnt == 2'(i))) ? word_new : sack_left[i];
      sack_right_next[i] = (wr_right && (sack_cnt == 2'(i))) ? word_new : sack_right[i];
    end
  end

  // The result reflects the state after the current byte has been applied.
  always_comb begin
    result            = '0;
    result.has_ts     = ts_seen_next;
    result.ts_value   = ts_seen_next ? ts_val_next : '0;
    result.ts_echo    = ts_seen_next ? ts_echo_next : '0;
    result.sack_count = sack_cnt_next;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (2'(i) < sack_cnt_next) begin
        result.sack_left[i]  = sack_left_next[i];
        result.sack_right[i] = sack_right_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      phase     <= PH_KIND;
      cur_kind  <= '0;
      remaining <= '0;
      body_off  <= '0;
      ts_seen   <= 1'b0;
      sack_cnt  <= '0;
    end else if (take) begin
      if (last) begin
        pos       <= '0;
        phase     <= PH_KIND;
        cur_kind  <= '0;
        remaining <= '0;
        body_off  <= '0;
        ts_seen   <= 1'b0;
        sack_cnt  <= '0;
      end else begin
        pos       <= pos_next;
        phase     <= phase_next;
        cur_kind  <= cur_kind_next;
        remaining <= remaining_next;
        body_off  <= body_off_next;
        ts_seen   <= ts_seen_next;
        sack_cnt  <= sack_cnt_next;
      end
    end
  end

  // Captured words are masked by ts_seen and sack_cnt, so they need no clearing.
  always_ff @(posedge clk) begin
    if (take) begin
      word    <= word_next;
      ts_val  <= ts_val_next;
      ts_echo <= ts_echo_next;
      ts_hold <= ts_hold_next;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        sack_left[i]  <= sack_left_next[i];
        sack_right[i] <= sack_right_next[i];
      end
    end
  end

endmodule

### design/tcp_opt_out.sv
// Result register that holds one parse result until the consumer takes it.
module tcp_opt_out
  import tcp_opt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

### design/tcp_option_parser_unit.sv
// TCP option parser top level: takes the option bytes of a header, one item per
// cycle, and on the item marked last returns the timestamp and SACK fields found.
// Every cycle one byte item can be accepted; the result for a header appears in
// the output register in the cycle after its last item is accepted. The input is
// stalled only while a finished result sits in the output register and the
// consumer stalls it. An empty option area is sent as a single last item.
module tcp_option_parser_unit
  import tcp_opt_pkg::*;
#(
  parameter int MAX_BLOCKS     = 3,
  parameter int MAX_AREA_BYTES = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  opt_byte,
  input  logic [5:0]  area_len,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        has_timestamps,
  output logic [31:0] ts_value,
  output logic [31:0] ts_echo,
  output logic [1:0]  sack_count,
  output logic [31:0] sack0_left,
  output logic [31:0] sack0_right,
  output logic [31:0] sack1_left,
  output logic [31:0] sack1_right,
  output logic [31:0] sack2_left,
  output logic [31:0] sack2_right
);

`include "tcp_option_parser_unit_defines.svh"

  logic    take;
  result_t result;
  result_t held;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  tcp_opt_walk #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .MAX_AREA_BYTES (MAX_AREA_BYTES)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .opt_byte (opt_byte),
    .area_len (area_len),
    .last     (last),
    .result   (result)
  );

  tcp_opt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && last),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .held      (held)
  );

  assign has_timestamps = held.has_ts;
  assign ts_value       = held.ts_value;
  assign ts_echo        = held.ts_echo;
  assign sack_count     = held.sack_count;
  assign sack0_left     = held.sack_left[0];
  assign sack0_right    = held.sack_right[0];
  assign sack1_left     = held.sack_left[1];
  assign sack1_right    = held.sack_right[1];
  assign sack2_left     = held.sack_left[2];
  assign sack2_right    = held.sack_right[2];

  `TOP_ASSERT_NEXT(a_last_gives_result, clk, rst, take && last, out_valid)
  `TOP_ASSERT_IMPLY(a_held_result_stalls_input, clk, rst, out_valid && out_stall, in_stall)
  `TOP_ASSERT_IMPLY(a_sack_count_bound, clk, rst, out_valid, sack_count <= 2'(MAX_BLOCKS))
  `TOP_ASSERT_IMPLY(a_no_ts_reads_zero, clk, rst, out_valid && !has_timestamps,
                    (ts_value == 32'd0) && (ts_echo == 32'd0))

endmodule

### tb/testbench.sv
// Self-checking testbench for the TCP option parser: random headers, stalls and a scoreboard.
module testbench;
  import tcp_opt_pkg::*;

  typedef logic [7:0] bytes_t[$];

  localparam int ITEMS      = 1400;
  localparam int TAIL_QUIET = 150;

  class option_scoreboard;
    localparam int AREA_MAX = 40;

    phase_t      phase;
    int unsigned pos;
    int unsigned rec_kind;
    int unsigned remain;
    int unsigned boff;
    logic [31:0] word;
    logic [31:0] ts_hold;
    result_t     acc;
    result_t     parsed_q[$];
    int          errors;
    int          headers;
    int          ts_headers;
    int          sack_blocks;

    function new();
      errors      = 0;
      headers     = 0;
      ts_headers  = 0;
      sack_blocks = 0;
      restart();
    endfunction

    function void restart();
      phase    = PH_KIND;
      pos      = 0;
      rec_kind = 0;
      remain   = 0;
      boff     = 0;
      word     = '0;
      ts_hold  = '0;
      acc      = '0;
    endfunction

    // Walks one accepted byte item through the option records.
    function void take_byte_item(logic [7:0] ob, logic [5:0] alen, logic lst);
      int unsigned len;
      result_t     want;
      int          i;
      len = (alen > AREA_MAX) ? AREA_MAX : alen;
      if (phase != PH_STOP && pos < len) begin
        case (phase)
          PH_KIND: begin
            if (ob == KIND_EOL) begin
              phase = PH_STOP;
            end else if (ob != KIND_NOP) begin
              // A kind with no room left for its length byte ends the walk.
              if (pos + 1 >= len) begin
                phase = PH_STOP;
              end else begin
                rec_kind = ob;
                phase    = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            if (ob < MIN_LEN || pos - 1 + ob > len) begin
              phase = PH_STOP;
            end else begin
              // Only SACK and well-sized timestamp records are captured.
              if (rec_kind != KIND_SACK && !(rec_kind == KIND_TS && ob == TS_LEN))
                rec_kind = 0;
              remain = ob - 2;
              boff   = 0;
              phase  = (remain == 0) ? PH_KIND : PH_BODY;
            end
          end
          default: begin
            word = {word[23:0], ob};
            boff = (boff + 1) % 64;
            if (rec_kind == KIND_TS) begin
              if (boff == 4) begin
                ts_hold = word;
              end else if (boff == 8) begin
                acc.has_ts   = 1'b1;
                acc.ts_value = ts_hold;
                acc.ts_echo  = word;
              end
            end else if (rec_kind == KIND_SACK && acc.sack_count < SACK_SLOTS) begin
              if (boff % 8 == 4) begin
                acc.sack_left[acc.sack_count] = word;
              end else if (boff % 8 == 0) begin
                acc.sack_right[acc.sack_count] = word;
                acc.sack_count = acc.sack_count + 1'b1;
              end
            end
            if (remain > 0) remain--;
            if (remain == 0) phase = PH_KIND;
          end
        endcase
      end
      if (pos < 63) pos++;
      if (lst) begin
        want            = '0;
        want.has_ts     = acc.has_ts;
        want.sack_count = acc.sack_count;
        if (acc.has_ts) begin
          want.ts_value = acc.ts_value;
          want.ts_echo  = acc.ts_echo;
        end
        for (i = 0; i < SACK_SLOTS; i++) begin
          if (i < acc.sack_count) begin
            want.sack_left[i]  = acc.sack_left[i];
            want.sack_right[i] = acc.sack_right[i];
          end
        end
        parsed_q.push_back(want);
        headers++;
        if (want.has_ts) ts_headers++;
        sack_blocks += want.sack_count;
        restart();
      end
    endfunction

    function void match(string what, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $display("%0t: %s expected %h got %h", $time, what, e, a);
        errors++;
      end
    endfunction

    function void check_parse(result_t got);
      result_t want;
      int      i;
      if (parsed_q.size() == 0) begin
        $display("%0t: parse result with none outstanding (has_ts %b, sack_count %0d)",
                 $time, got.has_ts, got.sack_count);
        errors++;
        return;
      end
      want = parsed_q.pop_front();
      match("has_timestamps", want.has_ts, got.has_ts);
      match("ts_value", want.ts_value, got.ts_value);
      match("ts_echo", want.ts_echo, got.ts_echo);
      match("sack_count", want.sack_count, got.sack_count);
      for (i = 0; i < SACK_SLOTS; i++) begin
        match($sformatf("sack%0d_left", i), want.sack_left[i], got.sack_left[i]);
        match($sformatf("sack%0d_right", i), want.sack_right[i], got.sack_right[i]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  opt_byte;
  logic [5:0]  area_len;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic        has_timestamps;
  logic [31:0] ts_value;
  logic [31:0] ts_echo;
  logic [1:0]  sack_count;
  logic [31:0] sack0_left;
  logic [31:0] sack0_right;
  logic [31:0] sack1_left;
  logic [31:0] sack1_right;
  logic [31:0] sack2_left;
  logic [31:0] sack2_right;

  option_scoreboard sb;
  bit               idle_on;
  int               items_sent;

  tcp_option_parser_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opt_byte       (opt_byte),
    .area_len       (area_len),
    .last           (last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .has_timestamps (has_timestamps),
    .ts_value       (ts_value),
    .ts_echo        (ts_echo),
    .sack_count     (sack_count),
    .sack0_left     (sack0_left),
    .sack0_right    (sack0_right),
    .sack1_left     (sack1_left),
    .sack1_right    (sack1_right),
    .sack2_left     (sack2_left),
    .sack2_right    (sack2_right)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Run timed out before all parse results arrived.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input logic [7:0] ob, input logic [5:0] alen, input logic lst);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opt_byte <= ob;
    area_len <= alen;
    last     <= lst;
    do @(posedge clk); while (in_stall);
    sb.take_byte_item(ob, alen, lst);
    items_sent++;
  endtask

  // An empty byte list still goes out as one item marked last.
  task automatic send_header(input bytes_t q, input logic [5:0] alen, input bit vary);
    logic [5:0] al;
    if (q.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), alen, 1'b1);
    end else begin
      foreach (q[i]) begin
        al = (vary && $urandom_range(0, 1)) ? 6'($urandom_range(0, 63)) : alen;
        send_item(q[i], al, i == q.size() - 1);
      end
    end
  endtask

  task automatic send_random_header();
    bytes_t     q;
    bytes_t     rec;
    int         nblk;
    int         cut;
    logic [7:0] olen;
    logic [5:0] alen;
    bit         vary;
    q.delete();
    repeat ($urandom_range(0, 6)) begin
      rec.delete();
      case ($urandom_range(0, 5))
        0: begin
          rec.push_back(KIND_TS);
          rec.push_back(TS_LEN);
          repeat (8) rec.push_back(8'($urandom_range(0, 255)));
        end
        1: begin
          nblk = $urandom_range(1, 4);
          rec.push_back(KIND_SACK);
          rec.push_back(8'(2 + 8 * nblk));
          repeat (8 * nblk) rec.push_back(8'($urandom_range(0, 255)));
        end
        2: rec.push_back(KIND_NOP);
        3: begin
          olen = 8'($urandom_range(2, 10));
          rec.push_back(8'($urandom_range(2, 255)));
          rec.push_back(olen);
          repeat (olen - 2) rec.push_back(8'($urandom_range(0, 255)));
        end
        4: begin
          olen = 8'($urandom_range(2, 26));
          rec.push_back(KIND_SACK);
          rec.push_back(olen);
          repeat (olen - 2) rec.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          olen = 8'($urandom_range(2, 12));
          rec.push_back(KIND_TS);
          rec.push_back(olen);
          repeat (olen - 2) rec.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      if (q.size() + rec.size() <= 40) begin
        foreach (rec[i]) q.push_back(rec[i]);
      end
    end
    if ($urandom_range(0, 3) == 0 && q.size() < 40) q.push_back(KIND_EOL);
    while (q.size() % 4 != 0 && $urandom_range(0, 3) != 0)
      q.push_back($urandom_range(0, 1) ? KIND_NOP : KIND_EOL);
    alen = 6'(q.size());
    vary = 1'b0;
    // Most headers stay well formed; the rest are broken in one way each.
    case ($urandom_range(0, 19))
      14: if (q.size() > 0) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      15: begin
        cut = (q.size() > 0) ? $urandom_range(0, q.size() - 1) : 0;
        while (q.size() > cut) void'(q.pop_back());
      end
      16: alen = 6'($urandom_range(0, q.size()));
      17: repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      18: begin
        if ($urandom_range(0, 1)) alen = 6'($urandom_range(41, 63));
        else vary = 1'b1;
      end
      19: begin
        q.delete();
        repeat ($urandom_range(0, 40)) q.push_back(8'($urandom_range(0, 255)));
        alen = 6'($urandom_range(0, 63));
      end
      default: ;
    endcase
    send_header(q, alen, vary);
  endtask

  initial begin
    result_t got;
    int      hold;
    out_stall = 1'b0;
    hold      = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        got.has_ts        = has_timestamps;
        got.ts_value      = ts_value;
        got.ts_echo       = ts_echo;
        got.sack_count    = sack_count;
        got.sack_left[0]  = sack0_left;
        got.sack_right[0] = sack0_right;
        got.sack_left[1]  = sack1_left;
        got.sack_right[1] = sack1_right;
        got.sack_left[2]  = sack2_left;
        got.sack_right[2] = sack2_right;
        sb.check_parse(got);
      end
      if (hold > 0) hold--;
      else if (idle_on && $urandom_range(0, 11) == 0) hold = $urandom_range(1, 19);
      out_stall <= (hold != 0);
    end
  end

  initial begin
    bytes_t q;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    opt_byte   = '0;
    area_len   = '0;
    last       = 1'b0;
    items_sent = 0;
    idle_on    = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    q.delete();
    send_header(q, 6'd0, 1'b0);
    q = '{KIND_TS, TS_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    send_header(q, 6'd10, 1'b0);
    q = '{KIND_SACK, 8'd10, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_header(q, 6'd10, 1'b0);
    q = '{KIND_EOL, KIND_TS};
    send_header(q, 6'd2, 1'b0);
    // A kind byte that is the final byte of the area.
    q = '{KIND_TS};
    send_header(q, 6'd1, 1'b0);
    q = '{KIND_SACK, 8'd1};
    send_header(q, 6'd2, 1'b0);

    while (items_sent < ITEMS) begin
      idle_on = (items_sent < ITEMS - TAIL_QUIET);
      send_random_header();
    end
    in_valid <= 1'b0;

    while (sb.parsed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d byte items forming %0d headers, clean and damaged, under random stalls.",
             items_sent, sb.headers);
    $display("%0d results carried timestamps; %0d SACK blocks were captured in all.",
             sb.ts_headers, sb.sack_blocks);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
